/* rtl/fbacc_pkg.sv */
// Package for the feather blend accumulator: widths, codes, the lane control struct.
// No dependencies; used by every other file of the block but fbacc_if.
package fbacc_pkg;

    localparam int ADDR_W     = 16;
    localparam int COLOUR_W   = 20;
    localparam int WEIGHT_W   = 12;
    localparam int CHANNELS   = 3;
    localparam int QUO_STEPS  = 8;
    localparam int STEP_W     = 3;
    localparam int DIM_W      = 9;

    localparam logic [DIM_W-1:0]    MAX_DIM    = 9'd256;
    localparam logic [ADDR_W-1:0]   LAST_ADDR  = 16'hFFFF;
    localparam logic [COLOUR_W-1:0] COLOUR_MAX = 20'hFFFFF;
    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = 12'hFFF;

    localparam logic OP_FEED = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic              rd;
        logic              wr;
        logic              clr;
        logic [ADDR_W-1:0] addr;
        logic              div_start;
        logic              div_step;
    } t_lane_ctl;

    typedef struct packed {
        logic       covered;
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
    } t_result;

endpackage

/* rtl/fbacc_if.sv */
// Handshake channels of the feather blend accumulator: feed/read requests and results.
// No dependencies.
interface fbacc_feed_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] offset_x;
    logic [7:0] offset_y;
    logic [7:0] local_x;
    logic [7:0] local_y;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] weight;

    modport source (output valid, op, offset_x, offset_y, local_x, local_y,
                    red, green, blue, weight, input ready);
    modport sink   (input valid, op, offset_x, offset_y, local_x, local_y,
                    red, green, blue, weight, output ready);
endinterface

interface fbacc_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       covered;

    modport source (output valid, out_red, out_green, out_blue, covered, input ready);
    modport sink   (input valid, out_red, out_green, out_blue, covered, output ready);
endinterface

/* rtl/fbacc_lane.sv */
// One colour channel lane: colour sum memory, saturating accumulate, 8-step divider.
// Depends on fbacc_pkg.
module fbacc_lane (
    input  logic                            i_clk,
    input  fbacc_pkg::t_lane_ctl            i_ctl,
    input  logic [7:0]                      i_pix,
    input  logic [7:0]                      i_weight,
    input  logic [fbacc_pkg::WEIGHT_W-1:0]  i_ws,
    output logic [7:0]                      o_quo
);

    logic [fbacc_pkg::COLOUR_W-1:0] r_mem [2**fbacc_pkg::ADDR_W];
    logic [fbacc_pkg::COLOUR_W-1:0] r_rd;
    logic [fbacc_pkg::COLOUR_W-1:0] r_rem;
    logic [fbacc_pkg::COLOUR_W-1:0] r_dvs;
    logic [7:0]                     r_q;
    logic                           r_sat;
    logic [15:0]                    n_prod;
    logic [fbacc_pkg::COLOUR_W:0]   n_sum;
    logic [fbacc_pkg::COLOUR_W-1:0] n_wdata;
    logic                           n_ge;

    // accumulate with saturation
    always_comb begin
        n_prod  = i_pix * i_weight;
        n_sum   = {1'b0, r_rd} + {{(fbacc_pkg::COLOUR_W-15){1'b0}}, n_prod};
        n_wdata = n_sum[fbacc_pkg::COLOUR_W] ? fbacc_pkg::COLOUR_MAX
                                            : n_sum[fbacc_pkg::COLOUR_W-1:0];
        if (i_ctl.clr) begin
            n_wdata = '0;
        end
        n_ge = (r_rem >= r_dvs);
    end

    // memory port: registered read, single write
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd) begin
            r_rd <= r_mem[i_ctl.addr];
        end
        if (i_ctl.wr) begin
            r_mem[i_ctl.addr] <= n_wdata;
        end
    end

    // restoring division, one quotient bit a cycle
    always_ff @(posedge i_clk) begin
        if (i_ctl.div_start) begin
            r_rem <= r_rd;
            r_dvs <= {1'b0, i_ws, 7'b0};
            r_q   <= '0;
            r_sat <= (r_rd >= {i_ws, 8'b0});
        end else if (i_ctl.div_step) begin
            r_rem <= n_ge ? (r_rem - r_dvs) : r_rem;
            r_dvs <= r_dvs >> 1;
            r_q   <= {r_q[6:0], n_ge};
        end
    end

    assign o_quo = r_sat ? 8'hFF : r_q;

endmodule

/* rtl/fbacc_merge.sv */
// Merge stage: combines lane quotients and coverage into the registered result beat.
// Depends on fbacc_pkg and fbacc_if.
module fbacc_merge (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic                 i_covered,
    input  logic [7:0]           i_quo [fbacc_pkg::CHANNELS],
    output logic                 o_room,
    fbacc_res_if.source          o_res
);

    logic                r_valid;
    fbacc_pkg::t_result  r_data;
    fbacc_pkg::t_result  n_data;

    assign o_room = !r_valid || o_res.ready;

    // zero the colour where nothing was fed
    always_comb begin
        n_data.covered   = i_covered;
        n_data.out_red   = i_covered ? i_quo[0] : 8'd0;
        n_data.out_green = i_covered ? i_quo[1] : 8'd0;
        n_data.out_blue  = i_covered ? i_quo[2] : 8'd0;
    end

    // hold the beat until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
        if (i_push) begin
            r_data <= n_data;
        end
    end

    assign o_res.valid     = r_valid;
    assign o_res.out_red   = r_data.out_red;
    assign o_res.out_green = r_data.out_green;
    assign o_res.out_blue  = r_data.out_blue;
    assign o_res.covered   = r_data.covered;

endmodule

/* rtl/feather_blend_accumulator_core.sv */
// Top level of the feather blend accumulator: control, weight memory, APB registers.
// Depends on fbacc_pkg, fbacc_if, fbacc_lane and fbacc_merge.
//
// After reset the block sweeps both 65536-entry stores to zero, one address a cycle; no
// beat is accepted meanwhile, register writes are. One item is worked at a time: a feed
// does address, memory read, write back of the saturated sums; a fed read does address,
// memory read, 8 quotient steps in each lane's divider, hand-off held until the merge
// stage has room, set by the single-port read-modify-write of the stores and the bit-serial
// divider. Out-of-canvas feeds are dropped; out-of-canvas or unfed reads return zeros.
module feather_blend_accumulator_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    fbacc_feed_if.sink   i_feed,
    fbacc_res_if.source  o_res,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_LOOK, S_RMW, S_DIV, S_DONE} t_state;

    t_state                           r_state;
    logic [fbacc_pkg::ADDR_W-1:0]     r_clr_cnt;
    logic [fbacc_pkg::STEP_W-1:0]     r_div_cnt;
    logic [fbacc_pkg::DIM_W-1:0]      r_cw;
    logic [fbacc_pkg::DIM_W-1:0]      r_ch;
    logic                             r_op;
    logic                             r_hit;
    logic                             r_cov;
    logic [fbacc_pkg::ADDR_W-1:0]     r_addr;
    logic [7:0]                       r_pix [fbacc_pkg::CHANNELS];
    logic [7:0]                       r_w;
    logic [fbacc_pkg::WEIGHT_W-1:0]   r_wmem [2**fbacc_pkg::ADDR_W];
    logic [fbacc_pkg::WEIGHT_W-1:0]   r_ws;

    logic [fbacc_pkg::DIM_W-1:0]      n_cw;
    logic [fbacc_pkg::DIM_W-1:0]      n_ch;
    logic [fbacc_pkg::DIM_W-1:0]      n_x;
    logic [fbacc_pkg::DIM_W-1:0]      n_y;
    logic [16:0]                      n_row;
    logic [16:0]                      n_lin;
    logic                             n_hit;
    logic [fbacc_pkg::WEIGHT_W:0]     n_wsum;
    logic [fbacc_pkg::WEIGHT_W-1:0]   n_wdata;
    logic                             n_push;
    logic                             n_room;
    logic                             n_accept;
    logic                             n_cfg_wr;
    fbacc_pkg::t_lane_ctl             n_ctl;
    logic [7:0]                       n_quo [fbacc_pkg::CHANNELS];

    // configuration registers
    assign pready   = 1'b1;
    assign n_cfg_wr = psel && penable && pwrite;
    assign prdata   = {23'd0, (paddr[2] == fbacc_pkg::REG_HEIGHT) ? r_ch : r_cw};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cw <= fbacc_pkg::MAX_DIM;
            r_ch <= fbacc_pkg::MAX_DIM;
        end else if (n_cfg_wr) begin
            if (paddr[2] == fbacc_pkg::REG_WIDTH) begin
                r_cw <= pwdata[fbacc_pkg::DIM_W-1:0];
            end else begin
                r_ch <= pwdata[fbacc_pkg::DIM_W-1:0];
            end
        end
    end

    // canvas address of the incoming beat
    always_comb begin
        n_cw  = (r_cw > fbacc_pkg::MAX_DIM) ? fbacc_pkg::MAX_DIM : r_cw;
        n_ch  = (r_ch > fbacc_pkg::MAX_DIM) ? fbacc_pkg::MAX_DIM : r_ch;
        if (i_feed.op == fbacc_pkg::OP_READ) begin
            n_x = {1'b0, i_feed.local_x};
            n_y = {1'b0, i_feed.local_y};
        end else begin
            n_x = {1'b0, i_feed.offset_x} + {1'b0, i_feed.local_x};
            n_y = {1'b0, i_feed.offset_y} + {1'b0, i_feed.local_y};
        end
        n_hit = (n_x < n_cw) && (n_y < n_ch);
        n_row = n_y[7:0] * n_cw;
        n_lin = n_row + {8'd0, n_x};
    end

    assign i_feed.ready = (r_state == S_IDLE);
    assign n_accept     = i_feed.valid && i_feed.ready;

    // lane control
    always_comb begin
        n_ctl.rd        = (r_state == S_LOOK) && r_hit;
        n_ctl.wr        = (r_state == S_CLEAR) ||
                          ((r_state == S_RMW) && (r_op == fbacc_pkg::OP_FEED));
        n_ctl.clr       = (r_state == S_CLEAR);
        n_ctl.addr      = (r_state == S_CLEAR) ? r_clr_cnt : r_addr;
        n_ctl.div_start = (r_state == S_RMW) && (r_op == fbacc_pkg::OP_READ);
        n_ctl.div_step  = (r_state == S_DIV);
        n_wsum  = {1'b0, r_ws} + {5'd0, r_w};
        n_wdata = n_wsum[fbacc_pkg::WEIGHT_W] ? fbacc_pkg::WEIGHT_MAX
                                              : n_wsum[fbacc_pkg::WEIGHT_W-1:0];
        if (n_ctl.clr) begin
            n_wdata = '0;
        end
        n_push = (r_state == S_DONE) && n_room;
    end

    // weight sum memory
    always_ff @(posedge i_clk) begin
        if (n_ctl.rd) begin
            r_ws <= r_wmem[n_ctl.addr];
        end
        if (n_ctl.wr) begin
            r_wmem[n_ctl.addr] <= n_wdata;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_cnt <= '0;
            r_div_cnt <= '0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    r_clr_cnt <= r_clr_cnt + 1'b1;
                    if (r_clr_cnt == fbacc_pkg::LAST_ADDR) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (n_accept) begin
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    if (r_hit) begin
                        r_state <= S_RMW;
                    end else if (r_op == fbacc_pkg::OP_READ) begin
                        r_cov   <= 1'b0;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_RMW: begin
                    if (r_op == fbacc_pkg::OP_FEED) begin
                        r_state <= S_IDLE;
                    end else if (r_ws == '0) begin
                        r_cov   <= 1'b0;
                        r_state <= S_DONE;
                    end else begin
                        r_div_cnt <= '0;
                        r_state   <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_div_cnt <= r_div_cnt + 1'b1;
                    if (r_div_cnt == fbacc_pkg::STEP_W'(fbacc_pkg::QUO_STEPS - 1)) begin
                        r_cov   <= 1'b1;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (n_room) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // capture the accepted beat
    always_ff @(posedge i_clk) begin
        if (n_accept) begin
            r_op     <= i_feed.op;
            r_hit    <= n_hit;
            r_addr   <= n_lin[fbacc_pkg::ADDR_W-1:0];
            r_pix[0] <= i_feed.red;
            r_pix[1] <= i_feed.green;
            r_pix[2] <= i_feed.blue;
            r_w      <= i_feed.weight;
        end
    end

    for (genvar c = 0; c < fbacc_pkg::CHANNELS; c++) begin : g_lane
        fbacc_lane u_lane (
            .i_clk    (i_clk),
            .i_ctl    (n_ctl),
            .i_pix    (r_pix[c]),
            .i_weight (r_w),
            .i_ws     (r_ws),
            .o_quo    (n_quo[c])
        );
    end

    fbacc_merge u_merge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (n_push),
        .i_covered (r_cov),
        .i_quo     (n_quo),
        .o_room    (n_room),
        .o_res     (o_res)
    );

`ifndef SYNTHESIS
    a_div_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_div_cnt == fbacc_pkg::STEP_W'(fbacc_pkg::QUO_STEPS - 1))
        |=> r_state == S_DONE)
        else $error("divider did not hand off after last step");
    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_ctl.wr |-> !i_feed.ready)
        else $error("store written while accepting beats");
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_push |-> (!o_res.valid || o_res.ready))
        else $error("result pushed over a waiting beat");
`endif

endmodule

/* dv/fbacc_checker.sv */
// Checker for the feather blend accumulator: watches both channels, predicts read results.
// Depends on fbacc_pkg and fbacc_if; the testbench top mirrors register writes into it.
module fbacc_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fbacc_feed_if       feed,
    fbacc_res_if        res,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [8:0]  i_cfg_val,
    output int          o_errors,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [fbacc_pkg::COLOUR_W-1:0] red_sum   [0:65535];
    logic [fbacc_pkg::COLOUR_W-1:0] green_sum [0:65535];
    logic [fbacc_pkg::COLOUR_W-1:0] blue_sum  [0:65535];
    logic [fbacc_pkg::WEIGHT_W-1:0] wsum      [0:65535];
    logic [8:0]                     cvs_w;
    logic [8:0]                     cvs_h;
    fbacc_pkg::t_result             pixel_q[$];
    int                             errors;

    assign o_errors  = errors;
    assign o_pending = pixel_q.size();

    function automatic logic [fbacc_pkg::COLOUR_W-1:0] sat_colour(
            logic [fbacc_pkg::COLOUR_W-1:0] a, int b);
        int s;
        s = int'(a) + b;
        return (s > int'(fbacc_pkg::COLOUR_MAX)) ? fbacc_pkg::COLOUR_MAX
                                                 : fbacc_pkg::COLOUR_W'(s);
    endfunction

    function automatic logic [7:0] norm_chan(logic [fbacc_pkg::COLOUR_W-1:0] cs,
                                             logic [fbacc_pkg::WEIGHT_W-1:0] ws);
        int q;
        q = int'(cs) / int'(ws);
        return (q > 255) ? 8'd255 : 8'(q);
    endfunction

    // Accumulate feeds and predict reads at each accepted request beat
    always @(posedge i_clk) begin
        int                  w;
        int                  h;
        int                  x;
        int                  y;
        int                  a;
        int                  s;
        fbacc_pkg::t_result  r;
        if (!i_rst_n) begin
            for (int i = 0; i < 65536; i++) begin
                red_sum[i] = '0; green_sum[i] = '0; blue_sum[i] = '0; wsum[i] = '0;
            end
            cvs_w = fbacc_pkg::MAX_DIM;
            cvs_h = fbacc_pkg::MAX_DIM;
            pixel_q.delete();
            errors = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == fbacc_pkg::REG_WIDTH) cvs_w = i_cfg_val;
                else cvs_h = i_cfg_val;
            end
            w = (cvs_w > fbacc_pkg::MAX_DIM) ? int'(fbacc_pkg::MAX_DIM) : int'(cvs_w);
            h = (cvs_h > fbacc_pkg::MAX_DIM) ? int'(fbacc_pkg::MAX_DIM) : int'(cvs_h);
            if (feed.valid && feed.ready) begin
                if (feed.op == fbacc_pkg::OP_FEED) begin
                    x = feed.offset_x + feed.local_x;
                    y = feed.offset_y + feed.local_y;
                    if (x < w && y < h) begin
                        a = y * w + x;
                        s = int'(wsum[a]) + feed.weight;
                        wsum[a] = (s > int'(fbacc_pkg::WEIGHT_MAX)) ? fbacc_pkg::WEIGHT_MAX
                                                                   : fbacc_pkg::WEIGHT_W'(s);
                        red_sum[a]   = sat_colour(red_sum[a],   feed.red * feed.weight);
                        green_sum[a] = sat_colour(green_sum[a], feed.green * feed.weight);
                        blue_sum[a]  = sat_colour(blue_sum[a],  feed.blue * feed.weight);
                    end
                end else begin
                    r = '0;
                    x = feed.local_x;
                    y = feed.local_y;
                    if (x < w && y < h) begin
                        a = y * w + x;
                        if (wsum[a] != 0) begin
                            r.out_red   = norm_chan(red_sum[a], wsum[a]);
                            r.out_green = norm_chan(green_sum[a], wsum[a]);
                            r.out_blue  = norm_chan(blue_sum[a], wsum[a]);
                            r.covered   = 1'b1;
                        end
                    end
                    pixel_q.push_back(r);
                end
            end
            // Compare each result beat with the oldest predicted pixel
            if (res.valid && res.ready) begin
                if (pixel_q.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected result beat at %0t", $realtime);
                end else begin
                    r = pixel_q.pop_front();
                    if (res.out_red !== r.out_red || res.out_green !== r.out_green ||
                        res.out_blue !== r.out_blue || res.covered !== r.covered) begin
                        errors++;
                        if (errors <= 10)
                            $display("pixel mismatch: exp r%0d g%0d b%0d c%0d got r%0d g%0d b%0d c%0d",
                                     r.out_red, r.out_green, r.out_blue, r.covered,
                                     res.out_red, res.out_green, res.out_blue, res.covered);
                    end
                end
            end
        end
    end
endmodule

/* dv/tb_feather_blend_accumulator_core.sv */
// Testbench top for the feather blend accumulator: clock, reset, APB setup, request stimulus.
// Depends on fbacc_pkg, fbacc_if, fbacc_checker and the block itself.
module tb_feather_blend_accumulator_core;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        cfg_we;
    logic        cfg_idx;
    logic [8:0]  cfg_val;
    int          errors;
    int          pending;
    int          cycles;
    int          hold_cycles;
    bit          no_idle;
    bit          done;

    fbacc_feed_if feed();
    fbacc_res_if  res();

    feather_blend_accumulator_core i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_feed(feed.sink), .o_res(res.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    fbacc_checker i_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .feed(feed), .res(res),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_val(cfg_val),
        .o_errors(errors), .o_pending(pending)
    );

    assign cfg_we  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[2];
    assign cfg_val = pwdata[8:0];

    always begin
        i_clk = 1'b0; #5;
        i_clk = 1'b1; #5;
    end

    // Watchdog: room for the sweep after reset and every item with stalls, several times over
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 900000) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Result receiver: random stalls, one long hold-off, quiet stretch
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res.ready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            res.ready   <= 1'b0;
        end else begin
            res.ready <= no_idle || ($urandom_range(99) >= 26);
        end
    end

    task automatic apb_write(input logic idx, input logic [8:0] val);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= {23'd0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // Offer one request beat and hold it until accepted
    task automatic send_req(input logic op, input logic [7:0] ox, input logic [7:0] oy,
                            input logic [7:0] lx, input logic [7:0] ly, input logic [7:0] r,
                            input logic [7:0] g, input logic [7:0] b, input logic [7:0] w);
        while (!no_idle && $urandom_range(99) < 26) begin
            feed.valid <= 1'b0;
            @(posedge i_clk);
        end
        feed.valid <= 1'b1; feed.op <= op;
        feed.offset_x <= ox; feed.offset_y <= oy; feed.local_x <= lx; feed.local_y <= ly;
        feed.red <= r; feed.green <= g; feed.blue <= b; feed.weight <= w;
        do @(posedge i_clk); while (!feed.ready);
    endtask

    task automatic drain();
        feed.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // Random phase on a canvas region of the given span so reads hit fed pixels
    task automatic random_phase(input int n, input int span);
        logic [7:0] ox, oy;
        for (int i = 0; i < n; i++) begin
            ox = 8'($urandom_range(span)); oy = 8'($urandom_range(span));
            if ($urandom_range(9) == 0) begin
                send_req(1'($urandom_range(1)), 8'($urandom), 8'($urandom), 8'($urandom),
                         8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                         8'($urandom));
            end else if ($urandom_range(2) == 0) begin
                send_req(fbacc_pkg::OP_READ, 8'($urandom), 8'($urandom), ox, oy,
                         8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            end else begin
                send_req(fbacc_pkg::OP_FEED, 8'(ox / 2), 8'(oy / 2), 8'(ox - ox / 2),
                         8'(oy - oy / 2), 8'($urandom), 8'($urandom), 8'($urandom),
                         ($urandom_range(3) == 0) ? 8'd255 : 8'($urandom));
            end
        end
        drain();
    endtask

    initial begin
        i_rst_n = 1'b0; psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        feed.valid = 1'b0; feed.op = fbacc_pkg::OP_FEED; feed.offset_x = '0;
        feed.offset_y = '0; feed.local_x = '0; feed.local_y = '0; feed.red = '0;
        feed.green = '0; feed.blue = '0; feed.weight = '0;
        cycles = 0; hold_cycles = 0; no_idle = 1'b0; done = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, zero weight, unfed reads, feeds and reads at the canvas corners
        send_req(fbacc_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0);
        send_req(fbacc_pkg::OP_FEED, 0, 0, 0, 0, 255, 0, 128, 0);
        send_req(fbacc_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0);
        for (int i = 0; i < 6; i++) send_req(fbacc_pkg::OP_FEED, 0, 0, 0, 0, 255, 255, 0, 255);
        send_req(fbacc_pkg::OP_FEED, 0, 0, 0, 0, 0, 0, 255, 1);
        send_req(fbacc_pkg::OP_READ, 255, 255, 0, 0, 0, 0, 0, 0);
        send_req(fbacc_pkg::OP_FEED, 255, 255, 0, 0, 1, 2, 3, 255);
        send_req(fbacc_pkg::OP_FEED, 128, 100, 127, 155, 9, 8, 7, 100);
        send_req(fbacc_pkg::OP_FEED, 200, 0, 55, 10, 10, 20, 30, 40);
        send_req(fbacc_pkg::OP_READ, 0, 0, 255, 10, 0, 0, 0, 0);
        send_req(fbacc_pkg::OP_READ, 0, 0, 255, 255, 0, 0, 0, 0);
        send_req(fbacc_pkg::OP_FEED, 0, 0, 255, 255, 170, 85, 240, 15);
        send_req(fbacc_pkg::OP_READ, 0, 0, 255, 255, 0, 0, 0, 0);
        drain();

        // Fill the pipe while the receiver holds off
        hold_cycles = 400;
        for (int i = 0; i < 12; i++) send_req(fbacc_pkg::OP_READ, 0, 0, 8'(i), 0, 0, 0, 0, 0);
        drain();

        random_phase(300, 15);
        apb_write(fbacc_pkg::REG_WIDTH, 9'd1); apb_write(fbacc_pkg::REG_HEIGHT, 9'd1);
        random_phase(150, 3);
        apb_write(fbacc_pkg::REG_WIDTH, 9'd0); apb_write(fbacc_pkg::REG_HEIGHT, 9'd300);
        random_phase(100, 7);
        apb_write(fbacc_pkg::REG_WIDTH, 9'd511); apb_write(fbacc_pkg::REG_HEIGHT, 9'd17);
        no_idle = 1'b1;
        random_phase(300, 20);
        no_idle = 1'b0;
        apb_write(fbacc_pkg::REG_WIDTH, 9'd13); apb_write(fbacc_pkg::REG_HEIGHT, 9'd256);
        random_phase(300, 15);
        apb_write(fbacc_pkg::REG_WIDTH, 9'd256); apb_write(fbacc_pkg::REG_HEIGHT, 9'd0);
        random_phase(100, 7);
        apb_write(fbacc_pkg::REG_WIDTH, 9'd256); apb_write(fbacc_pkg::REG_HEIGHT, 9'd256);
        random_phase(400, 255);

        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
